FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion helper macros, clocked on clk_i and disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define KIC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KIC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/kic_pkg.sv
// ----------------------------------------------------------------------------
// kic_pkg
// shared types, operator codes, characters and the keypad map of the calculator
// ----------------------------------------------------------------------------
`default_nettype none

package kic_pkg;

  // pending operator codes
  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_MOD  = 3'd5
  } op_e;

  // ascii characters
  localparam logic [7:0] CH_CLR  = 8'h43;  // 'C'
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_ADD  = 8'h2B;
  localparam logic [7:0] CH_SUB  = 8'h2D;
  localparam logic [7:0] CH_MUL  = 8'h2A;
  localparam logic [7:0] CH_DIV  = 8'h2F;
  localparam logic [7:0] CH_MOD  = 8'h25;
  localparam logic [7:0] CH_EQ   = 8'h3D;

  // request to the arithmetic unit
  typedef struct packed {
    logic start;
    op_e  op;
  } alu_req_t;

  // status from the arithmetic unit
  typedef struct packed {
    logic done;
  } alu_rsp_t;

  // 4x4 pad, row major
  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h37;
      4'd1:    c = 8'h38;
      4'd2:    c = 8'h39;
      4'd3:    c = CH_DIV;
      4'd4:    c = 8'h34;
      4'd5:    c = 8'h35;
      4'd6:    c = 8'h36;
      4'd7:    c = CH_MUL;
      4'd8:    c = 8'h31;
      4'd9:    c = 8'h32;
      4'd10:   c = 8'h33;
      4'd11:   c = CH_SUB;
      4'd12:   c = CH_CLR;
      4'd13:   c = CH_0;
      4'd14:   c = CH_MOD;
      default: c = CH_ADD;
    endcase
    return c;
  endfunction

  // operator character to code
  function automatic op_e op_code_of(input logic [7:0] c);
    op_e o;
    case (c)
      CH_ADD:  o = OP_ADD;
      CH_SUB:  o = OP_SUB;
      CH_MUL:  o = OP_MUL;
      CH_DIV:  o = OP_DIV;
      CH_MOD:  o = OP_MOD;
      default: o = OP_NONE;
    endcase
    return o;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/keypad_integer_calculator.sv
// ----------------------------------------------------------------------------
// keypad_integer_calculator
// five-function integer keypad calculator with an iterative arithmetic unit
// ----------------------------------------------------------------------------
// Usage:
//   input channel (in_valid_i / in_ready_o) carries one beat per key event:
//   cmd_i = 0 is a keypad press at key_index_i, cmd_i = 1 is an equals event.
//   output channel (out_valid_o / out_ready_i) returns exactly one beat per
//   input beat: echo, clear and result fields.
//   a keypad press is answered from the output register in the cycle after
//   it is taken. An equals event runs through the shared adder:
//   OPERAND_BITS steps for multiply, divide and modulo, one step otherwise;
//   the done flag and then the output register follow the last step.
//   throughput: one key event at a time; in_ready_o is low while the
//   arithmetic unit is busy and while an answer waits to be taken, so a slow
//   equals event holds the input until its answer reaches the output register.
//   reset clears both operands, the pending operator and the done phase and
//   empties the output register.
//   a stalled receiver holds the answer in the output register; no new key
//   event is taken until it drains.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module keypad_integer_calculator #(
  parameter int unsigned OPERAND_BITS = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic                    cmd_i,
  input  wire logic [3:0]              key_index_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic                         echo_valid_o,
  output logic      [7:0]              echo_char_o,
  output logic                         clear_screen_o,
  output logic                         result_valid_o,
  output logic      [OPERAND_BITS-1:0] result_value_o,
  output logic                         divide_by_zero_o
);
  import kic_pkg::*;

  localparam int unsigned N = OPERAND_BITS;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_CALC = 1'b1;

  logic         state_q, state_d;
  logic [N-1:0] first_q, first_d;
  logic [N-1:0] second_q, second_d;
  op_e          pend_q, pend_d;
  logic         done_ph_q, done_ph_d;
  logic         dz_q, dz_d;

  logic         out_valid_q, out_valid_d;
  logic         echo_valid_q, echo_valid_d;
  logic [7:0]   echo_char_q, echo_char_d;
  logic         clear_q, clear_d;
  logic         res_valid_q, res_valid_d;
  logic [N-1:0] res_value_q, res_value_d;
  logic         res_dz_q, res_dz_d;

  logic         in_acc;
  logic [7:0]   ch;
  logic         key_is_num;
  op_e          key_op;
  logic [N-1:0] digit_src, digit_val;
  alu_req_t     alu_req;
  alu_rsp_t     alu_rsp;
  logic [N-1:0] alu_res;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_acc     = in_valid_i && in_ready_o;

  // key decode
  assign ch         = key_char(key_index_i);
  assign key_is_num = (ch >= CH_0) && (ch <= CH_9);
  assign key_op     = op_code_of(ch);

  // decimal digit step: value * 10 + digit
  assign digit_src = (pend_q == OP_NONE) ? first_q : second_q;
  assign digit_val = {digit_src[N-4:0], 3'b000} + {digit_src[N-2:0], 1'b0}
                   + N'(ch - CH_0);

  // start the arithmetic unit on equals
  assign alu_req.start = in_acc && cmd_i;
  assign alu_req.op    = pend_q;

  kic_alu #(
    .OPERAND_BITS(OPERAND_BITS)
  ) u_alu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (alu_req),
    .a_i     (first_q),
    .b_i     (second_q),
    .rsp_o   (alu_rsp),
    .result_o(alu_res)
  );

  // calculator state and sequencer
  always_comb begin
    state_d   = state_q;
    first_d   = first_q;
    second_d  = second_q;
    pend_d    = pend_q;
    done_ph_d = done_ph_q;
    dz_d      = dz_q;
    if (in_acc) begin
      if (cmd_i) begin
        state_d   = S_CALC;
        done_ph_d = 1'b1;
        dz_d      = ((pend_q == OP_DIV) || (pend_q == OP_MOD)) && (second_q == '0);
      end else if (ch == CH_CLR) begin
        first_d   = '0;
        second_d  = '0;
        pend_d    = OP_NONE;
        done_ph_d = 1'b0;
      end else if (!done_ph_q) begin
        if (key_is_num) begin
          if (pend_q == OP_NONE) begin
            first_d = digit_val;
          end else begin
            second_d = digit_val;
          end
        end else if (key_op != OP_NONE) begin
          pend_d = key_op;
        end
      end
    end else if (alu_rsp.done) begin
      state_d = S_IDLE;
    end
  end

  // output beat register
  always_comb begin
    out_valid_d  = out_valid_q;
    echo_valid_d = echo_valid_q;
    echo_char_d  = echo_char_q;
    clear_d      = clear_q;
    res_valid_d  = res_valid_q;
    res_value_d  = res_value_q;
    res_dz_d     = res_dz_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (in_acc && !cmd_i) begin
      out_valid_d  = 1'b1;
      echo_valid_d = 1'b0;
      echo_char_d  = '0;
      clear_d      = (ch == CH_CLR);
      res_valid_d  = 1'b0;
      res_value_d  = '0;
      res_dz_d     = 1'b0;
      if (ch != CH_CLR && !done_ph_q && (key_is_num || key_op != OP_NONE)) begin
        echo_valid_d = 1'b1;
        echo_char_d  = ch;
      end
    end else if (alu_rsp.done) begin
      out_valid_d  = 1'b1;
      echo_valid_d = 1'b1;
      echo_char_d  = CH_EQ;
      clear_d      = 1'b0;
      res_valid_d  = 1'b1;
      res_value_d  = dz_q ? '0 : alu_res;
      res_dz_d     = dz_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      first_q     <= '0;
      second_q    <= '0;
      pend_q      <= OP_NONE;
      done_ph_q   <= 1'b0;
      dz_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      first_q     <= first_d;
      second_q    <= second_d;
      pend_q      <= pend_d;
      done_ph_q   <= done_ph_d;
      dz_q        <= dz_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload registers
  always_ff @(posedge clk_i) begin
    echo_valid_q <= echo_valid_d;
    echo_char_q  <= echo_char_d;
    clear_q      <= clear_d;
    res_valid_q  <= res_valid_d;
    res_value_q  <= res_value_d;
    res_dz_q     <= res_dz_d;
  end

  assign out_valid_o      = out_valid_q;
  assign echo_valid_o     = echo_valid_q;
  assign echo_char_o      = echo_char_q;
  assign clear_screen_o   = clear_q;
  assign result_valid_o   = res_valid_q;
  assign result_value_o   = res_value_q;
  assign divide_by_zero_o = res_dz_q;

  // checks
  `KIC_ASSERT_IMP(a_done_in_calc, alu_rsp.done, state_q == S_CALC, "alu done outside calc")
  `KIC_ASSERT_NXT(a_eq_to_calc, in_acc && cmd_i, state_q == S_CALC && done_ph_q, "no calc")
  `KIC_ASSERT_IMP(a_result_echo, out_valid_q && res_valid_q, echo_char_q == CH_EQ, "result without equals")
  `KIC_ASSERT_IMP(a_dz_zero, out_valid_q && res_dz_q, res_value_q == '0, "divide by zero not zero")

endmodule

`default_nettype wire

FILE: hw/rtl/kic_alu.sv
// ----------------------------------------------------------------------------
// kic_alu
// iterative arithmetic unit: one shared adder does add, subtract, shift-add
// multiply and restoring divide / modulo, one step per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module kic_alu #(
  parameter int unsigned OPERAND_BITS = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire kic_pkg::alu_req_t       req_i,
  input  wire logic [OPERAND_BITS-1:0] a_i,
  input  wire logic [OPERAND_BITS-1:0] b_i,
  output kic_pkg::alu_rsp_t            rsp_o,
  output logic      [OPERAND_BITS-1:0] result_o
);
  import kic_pkg::*;

  localparam int unsigned N  = OPERAND_BITS;
  localparam int unsigned W  = OPERAND_BITS + 2;
  localparam int unsigned CW = $clog2(OPERAND_BITS + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  op_e           op_q, op_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [N:0]    acc_q, acc_d;
  logic [N-1:0]  sh_q, sh_d;
  logic [N-1:0]  a_q, a_d;
  logic [N-1:0]  b_q, b_d;

  logic [N:0]    rem_shift;
  logic [W-1:0]  add_x, add_y, sum;
  logic          add_cin;
  logic          iterative;

  // partial remainder shifted left with the next dividend bit
  assign rem_shift = {acc_q[N-1:0], sh_q[N-1]};
  assign iterative = (req_i.op == OP_MUL) || (req_i.op == OP_DIV) || (req_i.op == OP_MOD);

  // shared adder operand selection
  always_comb begin
    add_x   = {2'b00, a_q};
    add_y   = '0;
    add_cin = 1'b0;
    case (op_q)
      OP_ADD: begin
        add_y = {2'b00, b_q};
      end
      OP_SUB: begin
        add_y   = ~{2'b00, b_q};
        add_cin = 1'b1;
      end
      OP_MUL: begin
        add_x = {1'b0, acc_q[N-1:0], 1'b0};
        add_y = sh_q[N-1] ? {2'b00, a_q} : '0;
      end
      OP_DIV, OP_MOD: begin
        add_x   = {1'b0, rem_shift};
        add_y   = ~{2'b00, b_q};
        add_cin = 1'b1;
      end
      default: begin
        add_y = '0;
      end
    endcase
  end

  assign sum = add_x + add_y + {{(W-1){1'b0}}, add_cin};

  // sequencing of the steps
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    sh_d   = sh_q;
    a_d    = a_q;
    b_d    = b_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      a_d    = a_i;
      b_d    = b_i;
      acc_d  = '0;
      cnt_d  = iterative ? CW'(N) : CW'(1);
      sh_d   = (req_i.op == OP_MUL) ? b_i : a_i;
    end else if (busy_q) begin
      case (op_q)
        OP_MUL: begin
          acc_d = {1'b0, sum[N-1:0]};
          sh_d  = {sh_q[N-2:0], 1'b0};
        end
        OP_DIV, OP_MOD: begin
          if (!sum[W-1]) begin
            acc_d = sum[N:0];
            sh_d  = {sh_q[N-2:0], 1'b1};
          end else begin
            acc_d = rem_shift;
            sh_d  = {sh_q[N-2:0], 1'b0};
          end
        end
        default: begin
          acc_d = {1'b0, sum[N-1:0]};
        end
      endcase
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_NONE;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    sh_q  <= sh_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign rsp_o.done = done_q;
  assign result_o   = (op_q == OP_DIV) ? sh_q : acc_q[N-1:0];

endmodule

`default_nettype wire
